FILE: hdl/scpd_pkg.sv
// scpd_pkg: shared types and constants of the sine crossing peak detector
// no dependencies; imported by scpd_core and sine_crossing_peak_detector
`default_nettype none

package scpd_pkg;

	localparam int SAMPLE_W = 8;
	localparam int P2P_W    = 9;

	localparam logic [SAMPLE_W-1:0] CNT_MAX     = 8'hff;
	localparam logic [SAMPLE_W-1:0] LEVEL_MAX   = 8'hff;
	localparam logic [SAMPLE_W-1:0] THR_DEFAULT = 8'h80;

	// register reset values
	localparam logic [7:0] RST_MIN_SWING  = 8'h20;
	localparam logic [6:0] RST_HYSTERESIS = 7'h08;
	localparam logic [7:0] RST_ACQUIRE    = 8'd128;
	localparam logic [7:0] RST_MIN_PERIOD = 8'h60;
	localparam logic [7:0] RST_EARLY_AT   = 8'd43;
	localparam logic [7:0] RST_LATE_AT    = 8'd59;
	localparam logic [7:0] RST_CLIP_HIGH  = 8'hf8;
	localparam logic [7:0] RST_CLIP_LOW   = 8'h08;

	typedef enum logic [2:0] {
		REG_MIN_SWING,
		REG_HYSTERESIS,
		REG_ACQUIRE,
		REG_MIN_PERIOD,
		REG_EARLY_AT,
		REG_LATE_AT,
		REG_CLIP_HIGH,
		REG_CLIP_LOW
	} reg_index_t;

	typedef enum logic [1:0] {
		POL_NONE = 2'b00,
		POL_HIGH = 2'b01,
		POL_LOW  = 2'b11
	} polarity_t;

	localparam logic signed [1:0] CROSS_NONE = 2'sb00;
	localparam logic signed [1:0] CROSS_RISE = 2'sb01;
	localparam logic signed [1:0] CROSS_FALL = 2'sb11;

	typedef struct packed {
		logic [7:0] min_swing;
		logic [6:0] hysteresis;
		logic [7:0] acquire_samples;
		logic [7:0] min_period;
		logic [7:0] early_sample_at;
		logic [7:0] late_sample_at;
		logic [7:0] clip_high;
		logic [7:0] clip_low;
	} cfg_t;

	typedef struct packed {
		logic signed [1:0]    crossing;
		logic [SAMPLE_W-1:0]  held_minimum;
		logic [SAMPLE_W-1:0]  held_maximum;
		logic [SAMPLE_W-1:0]  mid_threshold;
		logic [P2P_W-1:0]     peak_to_peak;
	} result_t;

endpackage

`default_nettype wire

FILE: hdl/scpd_sample_if.sv
// scpd_sample_if: valid/ready channel carrying one converter sample
// depends on nothing
`default_nettype none

interface scpd_sample_if;
	logic       valid;
	logic       ready;
	logic [7:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

`default_nettype wire

FILE: hdl/scpd_result_if.sv
// scpd_result_if: valid/ready channel carrying one detector result
// depends on nothing
`default_nettype none

interface scpd_result_if;
	logic              valid;
	logic              ready;
	logic signed [1:0] crossing;
	logic [7:0]        held_minimum;
	logic [7:0]        held_maximum;
	logic [7:0]        mid_threshold;
	logic [8:0]        peak_to_peak;

	modport source (output valid, output crossing, output held_minimum,
		output held_maximum, output mid_threshold, output peak_to_peak, input ready);
	modport sink (input valid, input crossing, input held_minimum,
		input held_maximum, input mid_threshold, input peak_to_peak, output ready);
endinterface

`default_nettype wire

FILE: hdl/scpd_core.sv
// scpd_core: detector state registers and the per-sample update logic
// depends on scpd_pkg
`default_nettype none

module scpd_core (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                step,
	input  wire logic [7:0]          sample,
	input  wire scpd_pkg::cfg_t      cfg,
	output      scpd_pkg::result_t   result
);
	import scpd_pkg::*;

	logic [7:0] cnt_q, rmin_q, rmax_q, early_q, late_q, thr_q, pmin_q, pmax_q;
	logic [8:0] p2p_q;
	polarity_t  pol_q;

	logic [7:0] cnt_d, rmin_d, rmax_d, early_d, late_d, thr_d, pmin_d, pmax_d;
	logic [8:0] p2p_d;
	polarity_t  pol_d;
	logic signed [1:0] cross_d;

	logic [7:0] cnt_inc, rmin_u, rmax_u, swing, clip_diff;
	logic [8:0] sum_mm, thr_hi, s_plus_hys;
	logic       lock_hi, lock_lo, clipped;

	always_comb begin
		cnt_inc    = (cnt_q == CNT_MAX) ? CNT_MAX : cnt_q + 8'd1;
		rmin_u     = (sample < rmin_q) ? sample : rmin_q;
		rmax_u     = (sample > rmax_q) ? sample : rmax_q;
		sum_mm     = {1'b0, rmax_u} + {1'b0, rmin_u};
		swing      = rmax_u - rmin_u;
		thr_hi     = {1'b0, thr_q} + {2'b00, cfg.hysteresis};
		s_plus_hys = {1'b0, sample} + {2'b00, cfg.hysteresis};
		lock_hi    = {1'b0, sample} > thr_hi;
		lock_lo    = s_plus_hys < {1'b0, thr_q};
		clip_diff  = early_d - late_d;
		clipped    = (rmax_u >= cfg.clip_high) || (rmin_u <= cfg.clip_low);
	end

	always_comb begin
		cnt_d   = cnt_inc;
		rmin_d  = rmin_u;
		rmax_d  = rmax_u;
		early_d = early_q;
		late_d  = late_q;
		thr_d   = thr_q;
		pmin_d  = pmin_q;
		pmax_d  = pmax_q;
		p2p_d   = p2p_q;
		pol_d   = pol_q;
		cross_d = CROSS_NONE;

		if (pol_q == POL_NONE) begin
			// acquisition
			if (cnt_inc == cfg.acquire_samples) begin
				pmin_d = rmin_u;
				pmax_d = rmax_u;
				if (rmax_u <= rmin_u || swing < cfg.min_swing) begin
					rmin_d = LEVEL_MAX;
					rmax_d = '0;
					cnt_d  = '0;
				end else begin
					thr_d = sum_mm[8:1];
				end
			end else if (cnt_inc == CNT_MAX) begin
				pmin_d = '0;
				pmax_d = '0;
				rmin_d = LEVEL_MAX;
				rmax_d = '0;
				cnt_d  = '0;
			end else if (cnt_inc > cfg.acquire_samples) begin
				if (lock_hi) begin
					pol_d   = POL_HIGH;
					cnt_d   = '0;
					cross_d = CROSS_RISE;
				end else if (lock_lo) begin
					pol_d   = POL_LOW;
					cnt_d   = '0;
					cross_d = CROSS_FALL;
				end
			end
		end else if (cnt_inc >= cfg.acquire_samples) begin
			// half-wave timeout
			pol_d  = POL_NONE;
			pmin_d = '0;
			pmax_d = '0;
			p2p_d  = '0;
			rmin_d = LEVEL_MAX;
			rmax_d = '0;
			cnt_d  = '0;
		end else begin
			if (cnt_inc == cfg.early_sample_at)
				early_d = sample;
			else if (cnt_inc == cfg.late_sample_at)
				late_d = sample;

			if (pol_q == POL_HIGH && sample < thr_q) begin
				pol_d   = POL_LOW;
				cross_d = CROSS_FALL;
			end else if (pol_q != POL_HIGH && sample > thr_q) begin
				pol_d   = POL_HIGH;
				cross_d = CROSS_RISE;
				if (cnt_inc < cfg.min_period) begin
					p2p_d = '0;
					thr_d = THR_DEFAULT;
				end else begin
					pmin_d = rmin_u;
					pmax_d = rmax_u;
					thr_d  = sum_mm[8:1];
					if (clipped)
						p2p_d = (early_d > late_d) ? {clip_diff, 1'b0} : '0;
					else
						p2p_d = (rmax_u > rmin_u) ? {1'b0, swing} : '0;
				end
				rmin_d = LEVEL_MAX;
				rmax_d = '0;
				cnt_d  = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			rmin_q  <= '0;
			rmax_q  <= '0;
			early_q <= '0;
			late_q  <= '0;
			thr_q   <= '0;
			pmin_q  <= '0;
			pmax_q  <= '0;
			p2p_q   <= '0;
			pol_q   <= POL_NONE;
		end else if (step) begin
			cnt_q   <= cnt_d;
			rmin_q  <= rmin_d;
			rmax_q  <= rmax_d;
			early_q <= early_d;
			late_q  <= late_d;
			thr_q   <= thr_d;
			pmin_q  <= pmin_d;
			pmax_q  <= pmax_d;
			p2p_q   <= p2p_d;
			pol_q   <= pol_d;
		end
	end

	// held fields show the state after this sample
	assign result = '{
		crossing:      cross_d,
		held_minimum:  pmin_d,
		held_maximum:  pmax_d,
		mid_threshold: thr_d,
		peak_to_peak:  p2p_d
	};

endmodule

`default_nettype wire

FILE: hdl/sine_crossing_peak_detector.sv
// sine_crossing_peak_detector: top level with register file and handshake stages
// depends on scpd_pkg, scpd_sample_if, scpd_result_if, scpd_core
//
// channel  | direction | contents
// in_ch    | sink      | sample (8 bit)
// out_ch   | source    | crossing, held_minimum, held_maximum, mid_threshold, peak_to_peak
// wr_*     | write     | register index (3 bit), data (8 bit)
//
// one sample per cycle sustained while out_ch accepts each result
// the state update sits between the input register and the result register
// a stalled output holds the result and backs up into the input register
// arst_n clears all detector state and loads the register defaults
`default_nettype none

module sine_crossing_peak_detector (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	scpd_sample_if.sink               in_ch,
	scpd_result_if.source             out_ch,
	input  wire logic                 wr_en,
	input  wire scpd_pkg::reg_index_t wr_index,
	input  wire logic [7:0]           wr_data
);
	import scpd_pkg::*;

	cfg_t       cfg_q;
	logic       valid_s1;
	logic [7:0] sample_s1;
	logic       out_valid_q;
	result_t    out_q;
	result_t    core_result;
	logic       advance;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_swing       <= RST_MIN_SWING;
			cfg_q.hysteresis      <= RST_HYSTERESIS;
			cfg_q.acquire_samples <= RST_ACQUIRE;
			cfg_q.min_period      <= RST_MIN_PERIOD;
			cfg_q.early_sample_at <= RST_EARLY_AT;
			cfg_q.late_sample_at  <= RST_LATE_AT;
			cfg_q.clip_high       <= RST_CLIP_HIGH;
			cfg_q.clip_low        <= RST_CLIP_LOW;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_MIN_SWING:  cfg_q.min_swing       <= wr_data;
				REG_HYSTERESIS: cfg_q.hysteresis      <= wr_data[6:0];
				REG_ACQUIRE:    cfg_q.acquire_samples <= wr_data;
				REG_MIN_PERIOD: cfg_q.min_period      <= wr_data;
				REG_EARLY_AT:   cfg_q.early_sample_at <= wr_data;
				REG_LATE_AT:    cfg_q.late_sample_at  <= wr_data;
				REG_CLIP_HIGH:  cfg_q.clip_high       <= wr_data;
				REG_CLIP_LOW:   cfg_q.clip_low        <= wr_data;
				default:        cfg_q.clip_low        <= cfg_q.clip_low;
			endcase
		end
	end

	assign advance     = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ch.ready)
			valid_s1 <= in_ch.valid;
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready)
			sample_s1 <= in_ch.sample;
	end

	scpd_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.sample (sample_s1),
		.cfg    (cfg_q),
		.result (core_result)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance)
			out_valid_q <= 1'b1;
		else if (out_ch.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance)
			out_q <= core_result;
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.crossing      = out_q.crossing;
	assign out_ch.held_minimum  = out_q.held_minimum;
	assign out_ch.held_maximum  = out_q.held_maximum;
	assign out_ch.mid_threshold = out_q.mid_threshold;
	assign out_ch.peak_to_peak  = out_q.peak_to_peak;

endmodule

`default_nettype wire
